// File: rtl/nc_pkg.sv
// Shared types and constants of the nearest-centroid classifier.
package nc_pkg;

   localparam int CLUSTER_W  = 4;
   localparam int FIELD_W    = 16;
   localparam int MAX_DIMS   = 4;
   localparam int DIST_W     = 34;
   localparam int COUNT_W    = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   localparam logic [COUNT_W-1:0] NUM_CLUSTERS_RESET = COUNT_W'(1);

   // Register word index of the single configuration register.
   localparam logic REG_NUM_CLUSTERS = 1'b0;

   typedef enum logic {
      REQ_WRITE    = 1'b0,
      REQ_CLASSIFY = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                               valid;
      req_kind_type                       kind;
      logic [CLUSTER_W-1:0]               slot;
      logic [MAX_DIMS-1:0][FIELD_W-1:0]   coord;
   } beat_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0] index;
      logic [DIST_W-1:0]    distance;
   } best_type;

endpackage

// File: rtl/nc_cell.sv
// One centroid cell of the chain: holds a centroid and updates the running best match.
module nc_cell import nc_pkg::*; #(
   parameter int CELL_IDX   = 0,
   parameter int DIMS       = 4,
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic [COUNT_W-1:0] num_clusters,
   input  beat_type           beat_in,
   input  best_type           best_in,
   output beat_type           beat_out,
   output best_type           best_out
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 2;

   logic signed [COORD_BITS-1:0] centroid_ff [DIMS];

   beat_type s1_beat_ff, s2_beat_ff, s3_beat_ff;
   best_type s1_best_ff, s2_best_ff, s3_best_ff, s3_best_in;

   logic signed [COORD_BITS:0]   diff   [DIMS];
   logic        [COORD_BITS-1:0] mag_in [DIMS];
   logic        [COORD_BITS-1:0] mag_ff [DIMS];
   logic        [SQ_W-1:0]       sq_ff  [DIMS];
   logic        [SUM_W-1:0]      sum;
   logic                         active;
   logic                         take;

   // Stage one: absolute coordinate differences against the stored centroid.
   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         diff[d] = {beat_in.coord[d][COORD_BITS-1], beat_in.coord[d][COORD_BITS-1:0]}
                 - {centroid_ff[d][COORD_BITS-1], centroid_ff[d]};
         mag_in[d] = diff[d][COORD_BITS] ? COORD_BITS'(-diff[d]) : diff[d][COORD_BITS-1:0];
      end
   end

   // A write beat loads this cell when it passes, so later classify beats see the new centroid.
   always_ff @(posedge clock) begin
      if (enable && beat_in.valid && beat_in.kind == REQ_WRITE &&
          int'(beat_in.slot) == CELL_IDX) begin
         for (int d = 0; d < DIMS; d++) begin
            centroid_ff[d] <= beat_in.coord[d][COORD_BITS-1:0];
         end
      end
   end

   // Stage three: sum the squares and keep the closer of this centroid and the incoming best.
   always_comb begin
      sum = '0;
      for (int d = 0; d < DIMS; d++) begin
         sum = sum + SUM_W'(sq_ff[d]);
      end
      active = (CELL_IDX == 0) || (int'(num_clusters) > CELL_IDX);
      take   = s2_beat_ff.valid && s2_beat_ff.kind == REQ_CLASSIFY && active &&
               ((CELL_IDX == 0) || (DIST_W'(sum) < s2_best_ff.distance));
      if (take) begin
         s3_best_in.index    = CLUSTER_W'(CELL_IDX);
         s3_best_in.distance = DIST_W'(sum);
      end else begin
         s3_best_in = s2_best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_beat_ff.valid <= 1'b0;
         s2_beat_ff.valid <= 1'b0;
         s3_beat_ff.valid <= 1'b0;
      end else if (enable) begin
         s1_beat_ff <= beat_in;
         s1_best_ff <= best_in;
         s2_beat_ff <= s1_beat_ff;
         s2_best_ff <= s1_best_ff;
         s3_beat_ff <= s2_beat_ff;
         s3_best_ff <= s3_best_in;
         for (int d = 0; d < DIMS; d++) begin
            mag_ff[d] <= mag_in[d];
            sq_ff[d]  <= mag_ff[d] * mag_ff[d];
         end
      end
   end

   assign beat_out = s3_beat_ff;
   assign best_out = s3_best_ff;

endmodule

// File: rtl/nc_out_reg.sv
// Result register at the end of the chain and the chain-wide advance signal.
module nc_out_reg import nc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  beat_type              last_beat,
   input  best_type              last_best,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  advance
);

   logic     rsp_valid_ff, rsp_valid_in;
   best_type rsp_best_ff;
   logic     last_is_result;
   logic     load;

   always_comb begin
      last_is_result = last_beat.valid && last_beat.kind == REQ_CLASSIFY;
      // The chain only halts when a finished result has nowhere to go.
      advance = !last_is_result || !rsp_valid_ff || rsp_tready;
      load    = advance && last_is_result;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_best_ff <= last_best;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - CLUSTER_W - DIST_W)'(0),
                        rsp_best_ff.distance, rsp_best_ff.index};

endmodule

// File: rtl/nearest_centroid_classifier.sv
// Nearest-centroid classifier: a chain of MAX_CLUSTERS centroid cells, three
// register stages each, through which write and classify beats flow in order.
// One beat is accepted every cycle while the result side keeps up; rsp_tvalid
// for a classify rises once its beat has passed the cell chain and then the
// result register. A write beat loads its slot when it reaches that cell and
// gives no result. Only a finished result that cannot be handed on halts the
// chain.
module nearest_centroid_classifier import nc_pkg::*; #(
   parameter int MAX_CLUSTERS = 16,
   parameter int DIMS         = 4,
   parameter int COORD_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cluster_index, coord_0, coord_1, coord_2, coord_3, then four zero bits
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // nearest_cluster, best_sq_distance, then two zero bits
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0] num_clusters_ff, num_clusters_in;
   logic               advance;

   beat_type chain_beat [MAX_CLUSTERS+1];
   best_type chain_best [MAX_CLUSTERS+1];

   always_comb begin
      num_clusters_in = num_clusters_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[2] == REG_NUM_CLUSTERS) begin
         num_clusters_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= NUM_CLUSTERS_RESET;
      end else begin
         num_clusters_ff <= num_clusters_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_NUM_CLUSTERS) ?
                       CSR_DATA_W'(num_clusters_ff) : '0;

   always_comb begin
      chain_beat[0].valid = req_tvalid;
      chain_beat[0].kind  = req_kind_type'(req_tuser);
      chain_beat[0].slot  = req_tdata[CLUSTER_W-1:0];
      for (int d = 0; d < MAX_DIMS; d++) begin
         chain_beat[0].coord[d] = req_tdata[CLUSTER_W + d*FIELD_W +: FIELD_W];
      end
      chain_best[0] = '0;
   end

   for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
      nc_cell #(
         .CELL_IDX   (k),
         .DIMS       (DIMS),
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .enable       (advance),
         .num_clusters (num_clusters_ff),
         .beat_in      (chain_beat[k]),
         .best_in      (chain_best[k]),
         .beat_out     (chain_beat[k+1]),
         .best_out     (chain_best[k+1])
      );
   end

   nc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .last_beat  (chain_beat[MAX_CLUSTERS]),
      .last_best  (chain_best[MAX_CLUSTERS]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .advance    (advance)
   );

   assign req_tready = advance;

endmodule

// File: rtl/nc_checker.sv
// Port-level checks of the nearest-centroid classifier, bound to the top level.
module nc_checker import nc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // When the result side takes beats, the chain never halts the input.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled although results are drained");

   // The padding above the distance field is always zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:CLUSTER_W+DIST_W] == '0)
      else $error("result padding bits set");

endmodule

bind nearest_centroid_classifier nc_checker u_nc_checker (.*);

// File: sim/nearest_centroid_classifier_tb.sv
// Self-checking testbench of the nearest-centroid classifier, with a scoreboard class.
module nearest_centroid_classifier_tb;
   import nc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS    = 16;
   localparam int PIPE_DEPTH   = 3 * NUM_SLOTS + 1;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 12;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASE_ITEMS  = 113;

   typedef logic [MAX_DIMS-1:0][FIELD_W-1:0] coords_type;

   class centroid_scoreboard;
      coords_type       centroids [NUM_SLOTS];
      logic [COUNT_W-1:0] num_clusters;
      best_type         pending_answers [$];
      int               mismatches;
      int               points_classified;
      int               centroids_loaded;

      function new();
         foreach (centroids[i]) centroids[i] = '0;
         num_clusters      = NUM_CLUSTERS_RESET;
         mismatches        = 0;
         points_classified = 0;
         centroids_loaded  = 0;
      endfunction

      function void set_num_clusters(logic [COUNT_W-1:0] value);
         num_clusters = value;
      endfunction

      // Zero counts as one and anything past the table saturates.
      function int searched_count();
         if (num_clusters == 0) return 1;
         if (num_clusters > NUM_SLOTS) return NUM_SLOTS;
         return int'(num_clusters);
      endfunction

      function logic [DIST_W-1:0] sq_distance(coords_type point, coords_type centre);
         longint sum;
         longint diff;
         sum = 0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            diff = longint'($signed(point[d])) - longint'($signed(centre[d]));
            sum += diff * diff;
         end
         return DIST_W'(sum);
      endfunction

      function void note_request(req_kind_type kind, logic [CLUSTER_W-1:0] slot,
                                 coords_type coords);
         best_type          best;
         logic [DIST_W-1:0] sq_dist;
         if (kind == REQ_WRITE) begin
            centroids[slot] = coords;
            centroids_loaded++;
            return;
         end
         best.index    = '0;
         best.distance = sq_distance(coords, centroids[0]);
         for (int c = 1; c < searched_count(); c++) begin
            sq_dist = sq_distance(coords, centroids[c]);
            // Strictly smaller only, so the lower index keeps a tie.
            if (sq_dist < best.distance) begin
               best.distance = sq_dist;
               best.index    = CLUSTER_W'(c);
            end
         end
         pending_answers.push_back(best);
         points_classified++;
      endfunction

      function void check_result(logic [CLUSTER_W-1:0] cluster,
                                 logic [DIST_W-1:0] sq_dist);
         best_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected result beat, cluster %0d distance %0d",
                     $time, cluster, sq_dist);
            mismatches++;
            return;
         end
         want = pending_answers.pop_front();
         if (cluster !== want.index) begin
            $display("%0t: nearest_cluster expected %0d actual %0d",
                     $time, want.index, cluster);
            mismatches++;
         end
         if (sq_dist !== want.distance) begin
            $display("%0t: best_sq_distance expected %0d actual %0d",
                     $time, want.distance, sq_dist);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   centroid_scoreboard sb;
   int cycle_count = 0;
   int beats_offered = 0;
   int settings_used = 0;
   int stall_left = 0;

   nearest_centroid_classifier i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic coords_type splat(logic [FIELD_W-1:0] value);
      return {MAX_DIMS{value}};
   endfunction

   function automatic logic [FIELD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   function automatic coords_type pick_coords();
      coords_type c;
      for (int d = 0; d < MAX_DIMS; d++) c[d] = pick_coord();
      return c;
   endfunction

   // A point jittered around a centroid, so that distances stay close and ties occur.
   function automatic coords_type near_centroid(coords_type centre, int spread);
      coords_type c;
      for (int d = 0; d < MAX_DIMS; d++)
         c[d] = centre[d] + FIELD_W'(int'($urandom_range(0, 2 * spread)) - spread);
      return c;
   endfunction

   // Sender gap: none in a calm window, otherwise mostly short and now and then long.
   function automatic int pick_gap();
      int r;
      if ((beats_offered % 230) < 40) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Each call starts and ends at a falling edge.
   task automatic send_request(input req_kind_type kind, input logic [CLUSTER_W-1:0] slot,
                               input coords_type coords);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {4'b0, coords, slot};
      beats_offered++;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, slot, coords);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (sb.pending_answers.size() != 0) @(posedge clock);
      // Write beats give no result but may still be travelling down the chain.
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_num_clusters(input logic [COUNT_W-1:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = CSR_ADDR_W'(4 * int'(REG_NUM_CLUSTERS));
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_num_clusters(value);
      settings_used++;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic run_random_phase(input int count);
      int         r;
      int         base;
      coords_type c;
      for (int n = 0; n < count; n++) begin
         r    = $urandom_range(0, 99);
         base = $urandom_range(0, sb.searched_count() - 1);
         if (r < 20) begin
            // Reload a slot: sometimes a copy of another centroid to build ties.
            if ($urandom_range(0, 3) == 0) c = sb.centroids[$urandom_range(0, NUM_SLOTS - 1)];
            else c = pick_coords();
            send_request(REQ_WRITE, CLUSTER_W'($urandom_range(0, NUM_SLOTS - 1)), c);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) c = near_centroid(sb.centroids[base], $urandom_range(1, 300));
            else if (r < 65) c = sb.centroids[base];
            else if (r < 80) c = pick_coords();
            else c = coords_type'({$urandom, $urandom});
            send_request(REQ_CLASSIFY, CLUSTER_W'($urandom), c);
         end
      end
   endtask

   // Result side stalls in runs; in a calm window it starts no new run, though a run already begun still ends.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else if ((cycle_count % 2000) < 300) begin
            rsp_tready = 1'b1;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b0;
            stall_left = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[CLUSTER_W-1:0], rsp_tdata[CLUSTER_W+DIST_W-1:CLUSTER_W]);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] settings [10];
      coords_type         c;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      sb = new();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: load every slot with the extremes and a tied pair, then classify.
      write_num_clusters(COUNT_W'(NUM_SLOTS));
      for (int s = 0; s < NUM_SLOTS; s++) begin
         case (s)
            0:       c = splat(16'h8000);
            1:       c = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
            3, 7:    c = {16'hfe70, 16'h012c, 16'hff38, 16'h0064};
            15:      c = splat(16'h7fff);
            default: c = pick_coords();
         endcase
         send_request(REQ_WRITE, CLUSTER_W'(s), c);
      end
      send_request(REQ_CLASSIFY, 4'h0, splat(16'h7fff));
      send_request(REQ_CLASSIFY, 4'hf, {16'hfe70, 16'h012c, 16'hff38, 16'h0064});
      send_request(REQ_CLASSIFY, 4'h5, splat(16'h0000));
      send_request(REQ_CLASSIFY, 4'ha, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      send_request(REQ_CLASSIFY, 4'h3, {16'hfe71, 16'h012b, 16'hff38, 16'h0064});
      drain_results();
      // With one cluster the all-positive point lies at the largest distance possible.
      write_num_clusters(COUNT_W'(1));
      send_request(REQ_CLASSIFY, 4'h9, splat(16'h7fff));
      send_request(REQ_CLASSIFY, 4'h6, splat(16'h8000));
      drain_results();

      settings = '{COUNT_W'(16), COUNT_W'(1), COUNT_W'(0), COUNT_W'(31), COUNT_W'(17),
                   COUNT_W'(2), COUNT_W'($urandom_range(3, 15)),
                   COUNT_W'($urandom_range(0, 31)), COUNT_W'(16),
                   COUNT_W'($urandom_range(1, 16))};
      foreach (settings[p]) begin
         write_num_clusters(settings[p]);
         run_random_phase(PHASE_ITEMS);
         drain_results();
      end

      $display("Classified %0d points and loaded %0d centroids under %0d cluster counts,",
               sb.points_classified, sb.centroids_loaded, settings_used);
      $display("including zero and counts above the table, in %0d cycles.", cycle_count);
      if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/nc_pkg.sv
rtl/nc_cell.sv
rtl/nc_out_reg.sv
rtl/nearest_centroid_classifier.sv
rtl/nc_checker.sv
sim/nearest_centroid_classifier_tb.sv
